/* design/afrp_pkg.sv */
// Package for the API frame receiver with controller pairing.
// Holds the shared constants, register and event codes and the result type.
// Used by the top level, the checker and the testbench; depends on nothing.
`default_nettype none

package afrp_pkg;

    localparam int FRAME_BYTES_DEF = 13;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam logic [7:0]  START_BYTE       = 8'h7E;
    localparam logic [15:0] UNSET_ADDR       = 16'hFFFF;
    localparam logic [7:0]  FIELD_RESET      = 8'hFF;
    localparam logic [7:0]  BUTTONS_RELEASED = 8'h00;
    localparam logic [16:0] OVERHEAD         = 17'd4;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd4000;
    localparam logic [7:0]  JOY_IDLE_RESET = 8'h7F;
    localparam logic [7:0]  TYPE_RESET     = 8'h81;

    localparam logic [7:0] STATUS_DRIVE  = 8'd0;
    localparam logic [7:0] STATUS_CHARGE = 8'd1;
    localparam logic [7:0] STATUS_PAIR   = 8'd2;

    typedef enum logic [1:0] {
        REG_TIMEOUT    = 2'd0,
        REG_JOY_IDLE   = 2'd1,
        REG_FRAME_TYPE = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        EV_IGNORED  = 3'd0,
        EV_IDLE     = 3'd1,
        EV_COMMAND  = 3'd2,
        EV_DUMP     = 3'd3,
        EV_CHARGE   = 3'd4,
        EV_PAIRED   = 3'd5,
        EV_UNPAIRED = 3'd6
    } event_code_t;

    typedef enum logic [1:0] {
        FS_OK       = 2'd0,
        FS_CHECKSUM = 2'd1,
        FS_BAD_TYPE = 2'd2,
        FS_TIMEOUT  = 2'd3
    } frame_status_t;

    typedef struct packed {
        event_code_t   event_code;
        frame_status_t frame_status;
        logic          paired;
        logic [15:0]   source_address;
        logic [7:0]    status_value;
        logic [7:0]    joystick_one;
        logic [7:0]    joystick_two;
        logic [7:0]    buttons;
    } result_t;

endpackage

`default_nettype wire

/* design/afrp_rx_if.sv */
// Stream interface for received bytes and timer ticks.
// Carries valid, ready and the cmd and rx_byte payload; no dependencies.
`default_nettype none

interface afrp_rx_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

`default_nettype wire

/* design/afrp_event_if.sv */
// Stream interface for frame and timeout events.
// Carries valid, ready and the event payload; no dependencies.
`default_nettype none

interface afrp_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_code;
    logic [1:0]  frame_status;
    logic        paired;
    logic [15:0] source_address;
    logic [7:0]  status_value;
    logic [7:0]  joystick_one;
    logic [7:0]  joystick_two;
    logic [7:0]  buttons;

    modport source (output valid, output event_code, output frame_status, output paired,
                    output source_address, output status_value, output joystick_one,
                    output joystick_two, output buttons, input ready);
    modport sink   (input valid, input event_code, input frame_status, input paired,
                    input source_address, input status_value, input joystick_one,
                    input joystick_two, input buttons, output ready);
endinterface

`default_nettype wire

/* design/api_frame_receiver_pairing_top.sv */
// Top level of the API frame receiver with controller pairing.
// Depends on afrp_pkg, afrp_rx_if and afrp_event_if.
//
// Channel     Direction  Transfer contents
// rx_chan     in         cmd (byte or tick), rx_byte
// event_chan  out        event, frame status, pairing flag, address and fields
// apb         in/out     timeout, joystick idle value, accepted frame type
//
// One item is taken per cycle while rx_chan.ready holds; results are registered.
// All frame state is held in flip-flops and updated in the cycle of the transfer.
// A two-entry output buffer lets input continue while a result is stalled;
// rx_chan.ready falls only while both entries are full.
// Async reset sets all but out_reg and skid_reg to start values at once.
`default_nettype none

module api_frame_receiver_pairing_top
    import afrp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    afrp_rx_if.sink            rx_chan,
    afrp_event_if.source       event_chan,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [ADDR_W-1:0]   paddr,
    input  wire [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [15:0] timeout_reg;
    logic [7:0]  joy_idle_reg;
    logic [7:0]  frame_type_reg;

    logic        in_frame_reg, in_frame_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [16:0] frame_length_reg, frame_length_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  store_reg [FRAME_BYTES];
    logic [7:0]  store_next [FRAME_BYTES];
    logic        pair_reg, pair_next;
    logic [15:0] partner_reg, partner_next;
    logic [7:0]  status_value_reg, status_value_next;
    logic [7:0]  joy_one_reg, joy_one_next;
    logic [7:0]  joy_two_reg, joy_two_next;
    logic [7:0]  button_reg, button_next;
    logic [15:0] silence_reg, silence_next;
    logic        armed_reg, armed_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_reg, skid_next;

    logic        accept;
    logic        res_valid;
    result_t     res;
    logic [4:0]  n;
    logic [16:0] length_now;
    logic [15:0] silence_inc;
    logic [7:0]  calc_sum;
    event_code_t ev;
    reg_index_t  wr_index;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign wr_index  = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (wr_index)
            REG_TIMEOUT:    prdata = {16'd0, timeout_reg};
            REG_JOY_IDLE:   prdata = {24'd0, joy_idle_reg};
            REG_FRAME_TYPE: prdata = {24'd0, frame_type_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            joy_idle_reg   <= JOY_IDLE_RESET;
            frame_type_reg <= TYPE_RESET;
        end
        else if (cfg_write)
        begin
            case (wr_index)
                REG_TIMEOUT:    timeout_reg    <= pwdata[15:0];
                REG_JOY_IDLE:   joy_idle_reg   <= pwdata[7:0];
                REG_FRAME_TYPE: frame_type_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    assign rx_chan.ready = !skid_valid_reg;
    assign accept        = rx_chan.valid && rx_chan.ready;

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        byte_index_next   = byte_index_reg;
        frame_length_next = frame_length_reg;
        running_sum_next  = running_sum_reg;
        store_next        = store_reg;
        pair_next         = pair_reg;
        partner_next      = partner_reg;
        status_value_next = status_value_reg;
        joy_one_next      = joy_one_reg;
        joy_two_next      = joy_two_reg;
        button_next       = button_reg;
        silence_next      = silence_reg;
        armed_next        = armed_reg;
        res_valid         = 1'b0;
        res               = '0;
        ev                = EV_IGNORED;

        n           = {1'b0, byte_index_reg} + 5'd1;
        length_now  = (n == 5'd3) ? OVERHEAD + {1'b0, store_reg[1], rx_chan.rx_byte}
                                  : frame_length_reg;
        silence_inc = (silence_reg == 16'hFFFF) ? silence_reg : silence_reg + 16'd1;
        calc_sum    = 8'hFF - running_sum_reg;

        if (accept)
        begin
            if (rx_chan.cmd)
            begin
                if (armed_reg)
                begin
                    if (silence_inc < timeout_reg)
                    begin
                        silence_next = silence_inc;
                    end
                    else
                    begin
                        armed_next        = 1'b0;
                        silence_next      = '0;
                        pair_next         = 1'b0;
                        partner_next      = UNSET_ADDR;
                        status_value_next = FIELD_RESET;
                        joy_one_next      = FIELD_RESET;
                        joy_two_next      = FIELD_RESET;
                        button_next       = FIELD_RESET;
                        res_valid         = 1'b1;
                        res.event_code    = EV_UNPAIRED;
                        res.frame_status  = FS_TIMEOUT;
                    end
                end
            end
            else if (!in_frame_reg)
            begin
                if (rx_chan.rx_byte == START_BYTE && byte_index_reg == 4'd0)
                begin
                    store_next[0]    = rx_chan.rx_byte;
                    byte_index_next  = 4'd1;
                    running_sum_next = '0;
                    in_frame_next    = 1'b1;
                end
            end
            else
            begin
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    if (byte_index_reg == 4'(i))
                    begin
                        store_next[i] = rx_chan.rx_byte;
                    end
                end
                frame_length_next = length_now;
                if (n > 5'(FRAME_BYTES))
                begin
                    in_frame_next   = 1'b0;
                    byte_index_next = '0;
                end
                else if ({12'd0, n} == length_now)
                begin
                    in_frame_next   = 1'b0;
                    byte_index_next = '0;
                    silence_next    = '0;
                    armed_next      = 1'b1;
                    if (calc_sum != rx_chan.rx_byte)
                    begin
                        res.frame_status = FS_CHECKSUM;
                    end
                    else if (store_next[3] != frame_type_reg)
                    begin
                        res.frame_status = FS_BAD_TYPE;
                    end
                    else
                    begin
                        res.frame_status = FS_OK;
                        if (partner_reg == UNSET_ADDR)
                        begin
                            partner_next = {store_next[4], store_next[5]};
                        end
                        status_value_next = store_next[8];
                        joy_one_next      = store_next[9];
                        joy_two_next      = store_next[10];
                        button_next       = store_next[11];
                    end

                    case (status_value_next)
                        STATUS_DRIVE:
                        begin
                            if (!pair_reg)
                                ev = EV_IGNORED;
                            else if (button_next == BUTTONS_RELEASED
                                     && joy_one_next == joy_idle_reg
                                     && joy_two_next == joy_idle_reg)
                                ev = EV_IDLE;
                            else if (button_next[0])
                                ev = EV_DUMP;
                            else
                                ev = EV_COMMAND;
                        end
                        STATUS_CHARGE:
                        begin
                            ev = pair_reg ? EV_CHARGE : EV_IGNORED;
                        end
                        STATUS_PAIR:
                        begin
                            if (pair_reg)
                            begin
                                ev = EV_IGNORED;
                            end
                            else
                            begin
                                ev        = EV_PAIRED;
                                pair_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            ev = EV_IGNORED;
                        end
                    endcase
                    res_valid      = 1'b1;
                    res.event_code = ev;
                end
                else
                begin
                    if (byte_index_reg >= 4'd3)
                    begin
                        running_sum_next = running_sum_reg + rx_chan.rx_byte;
                    end
                    byte_index_next = n[3:0];
                end
            end
        end

        res.paired         = pair_next;
        res.source_address = partner_next;
        res.status_value   = status_value_next;
        res.joystick_one   = joy_one_next;
        res.joystick_two   = joy_two_next;
        res.buttons        = button_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || event_chan.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_next       = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            byte_index_reg   <= '0;
            frame_length_reg <= '0;
            running_sum_reg  <= '0;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                store_reg[i] <= '0;
            end
            pair_reg         <= 1'b0;
            partner_reg      <= UNSET_ADDR;
            status_value_reg <= FIELD_RESET;
            joy_one_reg      <= FIELD_RESET;
            joy_two_reg      <= FIELD_RESET;
            button_reg       <= FIELD_RESET;
            silence_reg      <= '0;
            armed_reg        <= 1'b1;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            in_frame_reg     <= in_frame_next;
            byte_index_reg   <= byte_index_next;
            frame_length_reg <= frame_length_next;
            running_sum_reg  <= running_sum_next;
            store_reg        <= store_next;
            pair_reg         <= pair_next;
            partner_reg      <= partner_next;
            status_value_reg <= status_value_next;
            joy_one_reg      <= joy_one_next;
            joy_two_reg      <= joy_two_next;
            button_reg       <= button_next;
            silence_reg      <= silence_next;
            armed_reg        <= armed_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign event_chan.valid          = out_valid_reg;
    assign event_chan.event_code     = out_reg.event_code;
    assign event_chan.frame_status   = out_reg.frame_status;
    assign event_chan.paired         = out_reg.paired;
    assign event_chan.source_address = out_reg.source_address;
    assign event_chan.status_value   = out_reg.status_value;
    assign event_chan.joystick_one   = out_reg.joystick_one;
    assign event_chan.joystick_two   = out_reg.joystick_two;
    assign event_chan.buttons        = out_reg.buttons;

endmodule

`default_nettype wire

/* sim/afrp_event_checker.sv */
`timescale 1ns / 1ps
// Checker for the API frame receiver: it watches the byte/tick channel, the event channel
// and register writes, keeps its own framing, pairing and timer state and compares events.
// Depends on afrp_pkg; the testbench top instantiates it beside the block.
module afrp_event_checker
    import afrp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        rx_valid,
    input  wire                        rx_ready,
    input  wire                        rx_cmd,
    input  wire [7:0]                  rx_byte,
    input  wire                        ev_valid,
    input  wire                        ev_ready,
    input  wire [$bits(result_t)-1:0]  ev_data,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire                        pready,
    input  wire [ADDR_W-1:0]           paddr,
    input  wire [DATA_W-1:0]           pwdata,
    output int                         failures,
    output int                         pending
);

    logic        framing;
    logic [3:0]  pos_cnt;
    logic [16:0] total_len;
    logic [7:0]  sum_acc;
    logic [7:0]  frame_buf [FRAME_BYTES];
    logic        pair_state;
    logic [15:0] partner;
    logic [7:0]  status_byte;
    logic [7:0]  joy_a;
    logic [7:0]  joy_b;
    logic [7:0]  button_byte;
    logic [15:0] quiet_ticks;
    logic        watchdog_on;
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_joy_idle;
    logic [7:0]  cfg_type;
    result_t     awaited_events [$];
    result_t     oldest;
    int          fail_count = 0;

    function automatic void clear_partner_fields();
        partner     = UNSET_ADDR;
        status_byte = FIELD_RESET;
        joy_a       = FIELD_RESET;
        joy_b       = FIELD_RESET;
        button_byte = FIELD_RESET;
    endfunction

    function automatic void queue_event(event_code_t code, frame_status_t fs);
        result_t r;
        r.event_code     = code;
        r.frame_status   = fs;
        r.paired         = pair_state;
        r.source_address = partner;
        r.status_value   = status_byte;
        r.joystick_one   = joy_a;
        r.joystick_two   = joy_b;
        r.buttons        = button_byte;
        awaited_events.push_back(r);
    endfunction

    function automatic event_code_t classify_event();
        case (status_byte)
            STATUS_DRIVE: begin
                if (!pair_state)
                    return EV_IGNORED;
                if (button_byte == BUTTONS_RELEASED && joy_a == cfg_joy_idle
                    && joy_b == cfg_joy_idle)
                    return EV_IDLE;
                return button_byte[0] ? EV_DUMP : EV_COMMAND;
            end
            STATUS_CHARGE:
                return pair_state ? EV_CHARGE : EV_IGNORED;
            STATUS_PAIR: begin
                if (pair_state)
                    return EV_IGNORED;
                pair_state = 1'b1;
                return EV_PAIRED;
            end
            default:
                return EV_IGNORED;
        endcase
    endfunction

    function automatic void close_frame(logic [7:0] check_byte);
        logic [7:0]    calc;
        frame_status_t fs;
        calc        = 8'hFF - sum_acc;
        quiet_ticks = 16'd0;
        watchdog_on = 1'b1;
        if (calc != check_byte) begin
            fs = FS_CHECKSUM;
        end
        else if (frame_buf[3] != cfg_type) begin
            fs = FS_BAD_TYPE;
        end
        else begin
            fs = FS_OK;
            if (partner == UNSET_ADDR)
                partner = {frame_buf[4], frame_buf[5]};
            status_byte = frame_buf[8];
            joy_a       = frame_buf[9];
            joy_b       = frame_buf[10];
            button_byte = frame_buf[11];
        end
        queue_event(classify_event(), fs);
    endfunction

    function automatic void decode_rx_item(logic cmd, logic [7:0] b);
        logic [4:0] n;
        int         pos;
        if (cmd) begin
            if (watchdog_on) begin
                if (quiet_ticks != 16'hFFFF)
                    quiet_ticks++;
                if (quiet_ticks >= cfg_timeout) begin
                    watchdog_on = 1'b0;
                    quiet_ticks = 16'd0;
                    pair_state  = 1'b0;
                    clear_partner_fields();
                    queue_event(EV_UNPAIRED, FS_TIMEOUT);
                end
            end
        end
        else if (!framing) begin
            if (b == START_BYTE && pos_cnt == 4'd0) begin
                frame_buf[0] = b;
                pos_cnt      = 4'd1;
                sum_acc      = 8'h00;
                framing      = 1'b1;
            end
        end
        else begin
            pos = pos_cnt;
            n   = {1'b0, pos_cnt} + 5'd1;
            if (pos < FRAME_BYTES)
                frame_buf[pos] = b;
            if (n == 5'd3)
                total_len = OVERHEAD + {frame_buf[1], frame_buf[2]};
            if (n > FRAME_BYTES) begin
                framing = 1'b0;
                pos_cnt = 4'd0;
            end
            else if (n == total_len) begin
                framing = 1'b0;
                pos_cnt = 4'd0;
                close_frame(b);
            end
            else begin
                if (pos >= 3)
                    sum_acc += b;
                pos_cnt = n[3:0];
            end
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_event(result_t want, result_t got);
        check_field("event_code", want.event_code, got.event_code);
        check_field("frame_status", want.frame_status, got.frame_status);
        check_field("paired", want.paired, got.paired);
        check_field("source_address", want.source_address, got.source_address);
        check_field("status_value", want.status_value, got.status_value);
        check_field("joystick_one", want.joystick_one, got.joystick_one);
        check_field("joystick_two", want.joystick_two, got.joystick_two);
        check_field("buttons", want.buttons, got.buttons);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            framing     = 1'b0;
            pos_cnt     = 4'd0;
            total_len   = 17'd0;
            sum_acc     = 8'h00;
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_buf[i] = 8'h00;
            pair_state  = 1'b0;
            clear_partner_fields();
            quiet_ticks = 16'd0;
            watchdog_on = 1'b1;
            cfg_timeout  = TIMEOUT_RESET;
            cfg_joy_idle = JOY_IDLE_RESET;
            cfg_type     = TYPE_RESET;
            awaited_events.delete();
            pending  <= 0;
            failures <= fail_count;
        end
        else begin
            if (ev_valid && ev_ready) begin
                if (awaited_events.size() == 0) begin
                    $error("event transfer with no event awaited");
                    fail_count++;
                end
                else begin
                    oldest = awaited_events.pop_front();
                    compare_event(oldest, result_t'(ev_data));
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[3:2]))
                    REG_TIMEOUT:    cfg_timeout  = pwdata[15:0];
                    REG_JOY_IDLE:   cfg_joy_idle = pwdata[7:0];
                    REG_FRAME_TYPE: cfg_type     = pwdata[7:0];
                    default: ;
                endcase
            end
            if (rx_valid && rx_ready)
                decode_rx_item(rx_cmd, rx_byte);
            pending  <= awaited_events.size();
            failures <= fail_count;
        end
    end

endmodule

/* sim/api_frame_receiver_pairing_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the API frame receiver: it sends frames, noise and ticks with random
// idling on both channels, writes the registers between phases and gives the verdict.
// Depends on afrp_pkg, afrp_rx_if, afrp_event_if, the block and afrp_event_checker.
module api_frame_receiver_pairing_top_tb;
    import afrp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int FIELD_LEN    = 9;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                failures;
    int                pending;
    int                cycles = 0;
    int                items_sent = 0;
    bit                send_gaps = 1'b1;
    bit                take_gaps = 1'b1;
    bit                hold_request = 1'b0;
    logic [15:0]       cur_timeout = TIMEOUT_RESET;
    logic [7:0]        cur_joy_idle = JOY_IDLE_RESET;
    logic [7:0]        cur_type = TYPE_RESET;

    afrp_rx_if    rx_chan ();
    afrp_event_if event_chan ();

    api_frame_receiver_pairing_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_chan    (rx_chan),
        .event_chan (event_chan),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    afrp_event_checker event_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_chan.valid),
        .rx_ready (rx_chan.ready),
        .rx_cmd   (rx_chan.cmd),
        .rx_byte  (rx_chan.rx_byte),
        .ev_valid (event_chan.valid),
        .ev_ready (event_chan.ready),
        .ev_data  ({event_chan.event_code, event_chan.frame_status, event_chan.paired,
                    event_chan.source_address, event_chan.status_value,
                    event_chan.joystick_one, event_chan.joystick_two, event_chan.buttons}),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int stall;
        event_chan.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                event_chan.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = take_gaps ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                event_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            event_chan.ready <= 1'b1;
            do @(posedge clk);
            while (!(event_chan.valid && event_chan.ready) && !hold_request);
        end
    end

    task automatic send_item(logic cmd, logic [7:0] value);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            rx_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.cmd     <= cmd;
        rx_chan.rx_byte <= value;
        do @(posedge clk);
        while (!rx_chan.ready);
        items_sent++;
    endtask

    task automatic send_frame(logic [15:0] len, logic [7:0] ftype, logic [15:0] addr,
                              logic [7:0] st, logic [7:0] j1, logic [7:0] j2,
                              logic [7:0] btn, bit bad_sum);
        logic [7:0] body [11];
        logic [7:0] sum;
        int         n;
        foreach (body[i])
            body[i] = 8'($urandom);
        body[0] = ftype;
        body[1] = addr[15:8];
        body[2] = addr[7:0];
        body[5] = st;
        body[6] = j1;
        body[7] = j2;
        body[8] = btn;
        n   = (len < 16'd11) ? int'(len) : 11;
        sum = 8'h00;
        send_item(1'b0, START_BYTE);
        send_item(1'b0, len[15:8]);
        send_item(1'b0, len[7:0]);
        for (int i = 0; i < n; i++)
        begin
            send_item(1'b0, body[i]);
            sum += body[i];
        end
        sum = 8'hFF - sum;
        if (bad_sum)
            sum ^= 8'($urandom_range(1, 255));
        send_item(1'b0, sum);
    endtask

    task automatic send_random_frame(logic [15:0] len);
        logic [7:0]  ftype;
        logic [7:0]  st;
        logic [7:0]  j1;
        logic [7:0]  j2;
        logic [7:0]  btn;
        logic [15:0] addr;
        ftype = ($urandom_range(0, 9) != 0) ? cur_type : 8'($urandom);
        addr  = ($urandom_range(0, 7) == 0) ? UNSET_ADDR : 16'($urandom);
        case ($urandom_range(0, 6))
            0, 1:    st = STATUS_DRIVE;
            2:       st = STATUS_CHARGE;
            3, 4:    st = STATUS_PAIR;
            5:       st = FIELD_RESET;
            default: st = 8'($urandom);
        endcase
        j1 = ($urandom_range(0, 2) == 0) ? 8'($urandom) : cur_joy_idle;
        j2 = ($urandom_range(0, 2) == 0) ? 8'($urandom) : cur_joy_idle;
        case ($urandom_range(0, 3))
            0, 1:    btn = BUTTONS_RELEASED;
            2:       btn = 8'h01;
            default: btn = 8'($urandom);
        endcase
        send_frame(len, ftype, addr, st, j1, j2, btn, $urandom_range(0, 7) == 0);
    endtask

    task automatic random_unit();
        int kind;
        int burst;
        kind = $urandom_range(0, 19);
        if (kind < 12)
            send_random_frame(16'(FIELD_LEN));
        else if (kind < 14)
            send_random_frame(16'($urandom_range(0, FIELD_LEN - 1)));
        else if (kind == 14)
        begin
            case ($urandom_range(0, 2))
                0:       send_random_frame(16'd10);
                1:       send_random_frame(16'hFFFF);
                default: send_random_frame(16'($urandom_range(11, 65534)));
            endcase
        end
        else if (kind == 15)
        begin
            send_item(1'b0, START_BYTE);
            repeat ($urandom_range(0, 6)) send_item(1'b0, 8'($urandom));
        end
        else if (kind < 18)
        begin
            repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom));
        end
        else
        begin
            burst = (cur_timeout < 16'd20) ? int'(cur_timeout) + 2 : 20;
            repeat ($urandom_range(1, burst)) send_item(1'b1, 8'($urandom));
        end
    endtask

    task automatic settle();
        rx_chan.valid <= 1'b0;
        do @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                send_gaps = $urandom_range(0, 2) != 0;
                take_gaps = $urandom_range(0, 2) != 0;
            end
            random_unit();
        end
        settle();
    endtask

    task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk);
        while (!pready);
    endtask

    task automatic configure(logic [15:0] timeout, logic [7:0] joy_idle, logic [7:0] ftype);
        write_reg(REG_TIMEOUT, DATA_W'(timeout));
        write_reg(REG_JOY_IDLE, DATA_W'(joy_idle));
        write_reg(REG_FRAME_TYPE, DATA_W'(ftype));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_timeout  = timeout;
        cur_joy_idle = joy_idle;
        cur_type     = ftype;
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        rx_chan.valid   <= 1'b0;
        rx_chan.cmd     <= 1'b0;
        rx_chan.rx_byte <= 8'h00;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(1'b0, 8'h55);
        send_frame(16'(FIELD_LEN), TYPE_RESET, 16'h1234, STATUS_PAIR, JOY_IDLE_RESET,
                   JOY_IDLE_RESET, BUTTONS_RELEASED, 1'b0);
        send_frame(16'd0, TYPE_RESET, 16'h0000, STATUS_DRIVE, 8'h00, 8'h00, 8'h00, 1'b0);
        send_item(1'b1, 8'hAA);
        settle();
        run_phase(300);

        configure(16'd1, 8'h00, TYPE_RESET);
        run_phase(300);

        configure(16'hFFFF, 8'hFF, 8'h00);
        run_phase(200);

        configure(16'd3, JOY_IDLE_RESET, 8'hFF);
        send_gaps    = 1'b0;
        hold_request = 1'b1;
        repeat (30) send_random_frame(16'(FIELD_LEN));
        settle();
        send_gaps = 1'b1;
        run_phase(300);

        repeat (2)
        begin
            configure(16'($urandom_range(1, 12)), 8'($urandom), 8'($urandom));
            run_phase(100);
        end

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
